FILE: hdl/erol_pkg.sv
// Shared types and constants for the entry ring with byte-offset lookup.
package erol_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int HANDLE_W  = 32;
    localparam int LEN_W     = 16;
    localparam int OFF_W     = 20;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_FIND = 1'b1
    } t_op;

    typedef struct packed {
        t_op                 opcode;
        logic [HANDLE_W-1:0] new_handle;
        logic [LEN_W-1:0]    new_length;
        logic [OFF_W-1:0]    byte_offset;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] hit_handle;
        logic [LEN_W-1:0]    byte_in_entry;
        logic                displaced;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic step;
    } t_walk_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_ADD_RES,
        S_FIND_START,
        S_FIND_WALK,
        S_DONE
    } t_state;

endpackage

FILE: hdl/erol_store.sv
// Entry store: handle and length memories with one write and one registered read port.
module erol_store #(
    parameter int DEPTH  = erol_pkg::DEPTH_DEF,
    parameter int SLOT_W = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [SLOT_W-1:0]             i_wr_addr,
    input  logic [erol_pkg::HANDLE_W-1:0] i_wr_handle,
    input  logic [erol_pkg::LEN_W-1:0]    i_wr_length,
    input  logic [SLOT_W-1:0]             i_rd_addr,
    output logic [erol_pkg::HANDLE_W-1:0] o_rd_handle,
    output logic [erol_pkg::LEN_W-1:0]    o_rd_length
);
    import erol_pkg::*;

    logic [HANDLE_W-1:0] mem_handle [DEPTH];
    logic [LEN_W-1:0]    mem_length [DEPTH];
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [LEN_W-1:0]    r_rd_length;

    // Read returns the contents from before a write to the same slot.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_handle[i_wr_addr] <= i_wr_handle;
            mem_length[i_wr_addr] <= i_wr_length;
        end
        r_rd_handle <= mem_handle[i_rd_addr];
        r_rd_length <= mem_length[i_rd_addr];
    end

    assign o_rd_handle = r_rd_handle;
    assign o_rd_length = r_rd_length;

endmodule

FILE: hdl/erol_walk.sv
// Running length sum and offset compare unit, stepped once per visited entry.
module erol_walk #(
    parameter int DEPTH = erol_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  erol_pkg::t_walk_ctrl       i_ctrl,
    input  logic [erol_pkg::LEN_W-1:0] i_length,
    input  logic [erol_pkg::OFF_W-1:0] i_offset,
    output logic                       o_hit,
    output logic [erol_pkg::LEN_W-1:0] o_pos
);
    import erol_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = LEN_W + CNT_W;
    localparam int ACC_W = (SUM_W > OFF_W) ? SUM_W : OFF_W;

    logic [ACC_W-1:0] r_before;
    logic [ACC_W-1:0] n_before;
    logic [ACC_W-1:0] after;
    logic [ACC_W-1:0] offset_ext;
    logic [ACC_W-1:0] diff;

    assign offset_ext = ACC_W'(i_offset);
    assign after      = r_before + ACC_W'(i_length);
    assign diff       = offset_ext - r_before;
    assign o_hit      = offset_ext < after;
    assign o_pos      = diff[LEN_W-1:0];

    always_comb begin
        n_before = r_before;
        if (i_ctrl.clear) begin
            n_before = '0;
        end else if (i_ctrl.step) begin
            n_before = after;
        end
    end

    always_ff @(posedge i_clk) begin
        r_before <= n_before;
    end

endmodule

FILE: hdl/entry_ring_with_offset_lookup.sv
// Top level of the entry ring with byte-offset lookup: sequencer, ring pointers and output stage.
//
// The ring keeps DEPTH entries, each a 32-bit buffer handle and a 16-bit byte
// length, in a pair of single-port-write memories with a registered read. An
// add transaction writes the entry at the write slot; once the ring is full it
// overwrites the oldest entry and reports the displaced handle. A find
// transaction walks the stored entries from oldest to newest through one
// shared add-and-compare unit, one entry per clock, and returns the handle and
// the byte position of the entry that holds the requested offset of the
// concatenated data, or a not-found result. The block handles one transaction
// at a time: an add passes through the add, result and done states of the
// sequencer, and a find through the start state, the walk over the visited
// entries (at most DEPTH, through the memory read port) and the done state.
// The result sits in an output register, so the next input transaction is
// taken as soon as the sequencer is idle again, even while the previous result
// still waits to be taken; a further result waits in the sequencer until the
// output register frees up. Contents of entries that have never been written
// never reach a result, so the memories need no clearing after reset and a
// find is usable at once.
module entry_ring_with_offset_lookup #(
    parameter int DEPTH = erol_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  erol_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output erol_pkg::t_out_item o_out_data
);
    import erol_pkg::*;

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Sequencer state and the transaction being worked on.
    t_state     r_state;
    t_state     n_state;
    t_in_item   r_item;

    // Ring pointers. While the ring is not full the oldest slot stays at zero;
    // once it is full the oldest slot follows the write slot.
    logic [SLOT_W-1:0] r_wr_slot;
    logic [SLOT_W-1:0] r_old_slot;
    logic              r_full;
    logic [SLOT_W-1:0] n_wr_slot;
    logic [SLOT_W-1:0] n_old_slot;
    logic              n_full;

    // Walk bookkeeping: next slot to read and entries left to visit.
    logic [SLOT_W-1:0] r_rd_slot;
    logic [SLOT_W-1:0] n_rd_slot;
    logic [CNT_W-1:0]  r_left;
    logic [CNT_W-1:0]  n_left;
    logic              r_disp;
    logic              n_disp;

    // Finished result waiting for the output register, and the output register.
    t_out_item r_res;
    t_out_item n_res;
    t_out_item r_out;
    logic      r_out_valid;
    logic      out_free;

    // Memory and walk unit hookup.
    logic                 st_we;
    logic [SLOT_W-1:0]    st_rd_addr;
    logic [HANDLE_W-1:0]  rd_handle;
    logic [LEN_W-1:0]     rd_length;
    t_walk_ctrl           walk_ctrl;
    logic                 walk_hit;
    logic [LEN_W-1:0]     walk_pos;

    logic [CNT_W-1:0]  stored_cnt;
    logic [SLOT_W-1:0] wr_next;
    logic [SLOT_W-1:0] old_next;
    logic [SLOT_W-1:0] rd_next;
    logic [SLOT_W-1:0] old_after;
    logic              in_acc;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] res;
        if (s == SLOT_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = s + 1'b1;
        end
        return res;
    endfunction

    assign wr_next   = slot_inc(r_wr_slot);
    assign old_next  = slot_inc(r_old_slot);
    assign rd_next   = slot_inc(r_rd_slot);
    assign old_after = slot_inc(r_old_slot);

    // Number of entries held: DEPTH when full, otherwise the pointer distance.
    always_comb begin
        if (r_full) begin
            stored_cnt = CNT_W'(DEPTH);
        end else if (r_wr_slot >= r_old_slot) begin
            stored_cnt = CNT_W'(r_wr_slot - r_old_slot);
        end else begin
            stored_cnt = CNT_W'(DEPTH) - CNT_W'(r_old_slot) + CNT_W'(r_wr_slot);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    erol_store #(
        .DEPTH  (DEPTH),
        .SLOT_W (SLOT_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (st_we),
        .i_wr_addr   (r_wr_slot),
        .i_wr_handle (r_item.new_handle),
        .i_wr_length (r_item.new_length),
        .i_rd_addr   (st_rd_addr),
        .o_rd_handle (rd_handle),
        .o_rd_length (rd_length)
    );

    erol_walk #(
        .DEPTH (DEPTH)
    ) u_walk (
        .i_clk    (i_clk),
        .i_ctrl   (walk_ctrl),
        .i_length (rd_length),
        .i_offset (r_item.byte_offset),
        .o_hit    (walk_hit),
        .o_pos    (walk_pos)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.opcode == OP_FIND) ? S_FIND_START : S_ADD;
                end
            end
            S_ADD: begin
                n_state = S_ADD_RES;
            end
            S_ADD_RES: begin
                n_state = S_DONE;
            end
            S_FIND_START: begin
                n_state = (stored_cnt == '0) ? S_DONE : S_FIND_WALK;
            end
            S_FIND_WALK: begin
                if (walk_hit || (r_left == CNT_W'(1))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer: strobes and next values of the datapath.
    always_comb begin
        st_we      = 1'b0;
        st_rd_addr = r_rd_slot;
        walk_ctrl  = '0;
        n_wr_slot  = r_wr_slot;
        n_old_slot = r_old_slot;
        n_full     = r_full;
        n_rd_slot  = r_rd_slot;
        n_left     = r_left;
        n_disp     = r_disp;
        n_res      = r_res;
        case (r_state)
            S_IDLE: begin
            end
            S_ADD: begin
                // Write the new entry and read the one it replaces in the same cycle.
                st_we      = 1'b1;
                st_rd_addr = r_wr_slot;
                n_disp     = r_full;
                n_wr_slot  = wr_next;
                if (r_full) begin
                    n_old_slot = old_next;
                end
                if (wr_next == '0) begin
                    n_full = 1'b1;
                end
            end
            S_ADD_RES: begin
                n_res               = '0;
                n_res.displaced     = r_disp;
                n_res.hit_handle    = r_disp ? rd_handle : '0;
            end
            S_FIND_START: begin
                st_rd_addr      = r_old_slot;
                n_rd_slot       = old_after;
                n_left          = stored_cnt;
                walk_ctrl.clear = 1'b1;
                n_res           = '0;
            end
            S_FIND_WALK: begin
                // Compare the entry read last cycle while fetching the next one.
                st_rd_addr     = r_rd_slot;
                n_rd_slot      = rd_next;
                n_left         = r_left - 1'b1;
                walk_ctrl.step = 1'b1;
                n_res          = '0;
                if (walk_hit) begin
                    n_res.found         = 1'b1;
                    n_res.hit_handle    = rd_handle;
                    n_res.byte_in_entry = walk_pos;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_slot   <= '0;
            r_old_slot  <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_slot  <= n_wr_slot;
            r_old_slot <= n_old_slot;
            r_full     <= n_full;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        r_rd_slot <= n_rd_slot;
        r_left    <= n_left;
        r_disp    <= n_disp;
        r_res     <= n_res;
        if ((r_state == S_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A walk always has at least one entry left to visit.
    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND_WALK) |-> (r_left != '0))
        else $error("walk entered with no entries left");

    // Before the ring first fills, the oldest entry is always in slot zero.
    a_old_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_full |-> (r_old_slot == '0))
        else $error("oldest slot moved before the ring was full");

    // A full ring has its oldest entry exactly where the next add writes.
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_old_slot == r_wr_slot))
        else $error("full ring with oldest and write slots apart");

    // A new result appears only after the sequencer has finished a transaction.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result presented without a finished transaction");

endmodule
